// ===== rtl/bacd_pkg.sv =====
// Shared types and constants for the block address cookie decoder.
// Used by bacd_decoder, bacd_scale and block_address_cookie_decoder.
`timescale 1ns / 1ps
`default_nettype none

package bacd_pkg;

	// Position inside one packed integer.
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_MULTI  = 3'b100
	} phase_t;

	// Which of the three integers of a cookie is being decoded.
	typedef enum logic [1:0] {
		FLD_OFFSET = 2'd0,
		FLD_SIZE   = 2'd1,
		FLD_CHECK  = 2'd2
	} field_t;

	localparam logic [6:0]  SHORT_BIAS       = 7'd64;
	localparam logic [13:0] LONG_BIAS        = 14'd8256;
	localparam logic [16:0] BLOCK_SIZE_RESET = 17'd4096;

	// Operands handed from the decoder to the scaling pipeline.
	typedef struct packed {
		logic        valid;
		logic        bad;
		logic [63:0] off_inc;
		logic [63:0] size;
	} scale_req_t;

endpackage

`default_nettype wire

// ===== rtl/bacd_decoder.sv =====
// Byte-wise decoder of the three packed integers of a block address cookie.
// Depends on bacd_pkg for the phase and field codes and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module bacd_decoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        in_byte,
	input  wire logic              cookie_start,
	output bacd_pkg::scale_req_t   req
);

	bacd_pkg::phase_t phase_q, phase_e, phase_n;
	bacd_pkg::field_t field_q, field_e, field_n;
	logic [3:0]  bl_q, bl_e, bl_n;
	logic [63:0] acc_q, acc_e, acc_n;
	logic [63:0] saved_off_q, saved_off_n;
	logic [63:0] saved_size_q, saved_size_n;
	logic        skip_q, skip_e, skip_n;
	logic        done;
	logic        bad;
	logic [63:0] value;
	logic [63:0] shifted;

	always_comb begin
		// A cookie start drops any partial value before this byte is looked at.
		phase_e = cookie_start ? bacd_pkg::PH_FIRST : phase_q;
		field_e = cookie_start ? bacd_pkg::FLD_OFFSET : field_q;
		bl_e    = cookie_start ? 4'd0 : bl_q;
		acc_e   = cookie_start ? 64'd0 : acc_q;
		skip_e  = cookie_start ? 1'b0 : skip_q;

		phase_n      = phase_e;
		field_n      = field_e;
		bl_n         = bl_e;
		acc_n        = acc_e;
		skip_n       = skip_e;
		saved_off_n  = saved_off_q;
		saved_size_n = saved_size_q;
		done         = 1'b0;
		bad          = 1'b0;
		value        = 64'd0;
		shifted      = {acc_e[55:0], in_byte};

		req.valid   = 1'b0;
		req.bad     = 1'b0;
		req.off_inc = 64'd0;
		req.size    = 64'd0;

		if (!skip_e) begin
			unique case (phase_e)
				bacd_pkg::PH_SECOND: begin
					value   = 64'({1'b0, acc_e[12:0] | {5'b0, in_byte}} +
						14'(bacd_pkg::SHORT_BIAS));
					phase_n = bacd_pkg::PH_FIRST;
					done    = 1'b1;
				end
				bacd_pkg::PH_MULTI: begin
					acc_n = shifted;
					bl_n  = bl_e - 4'd1;
					if (bl_n == 4'd0) begin
						value   = shifted + 64'(bacd_pkg::LONG_BIAS);
						phase_n = bacd_pkg::PH_FIRST;
						done    = 1'b1;
					end
				end
				default: begin
					unique case (in_byte[7:4])
						4'h8, 4'h9, 4'hA, 4'hB: begin
							value = {58'd0, in_byte[5:0]};
							done  = 1'b1;
						end
						4'hC, 4'hD: begin
							acc_n   = {51'd0, in_byte[4:0], 8'd0};
							phase_n = bacd_pkg::PH_SECOND;
						end
						4'hE: begin
							acc_n = 64'd0;
							bl_n  = in_byte[3:0];
							if (in_byte[3:0] == 4'd0) begin
								value = 64'(bacd_pkg::LONG_BIAS);
								done  = 1'b1;
							end else begin
								phase_n = bacd_pkg::PH_MULTI;
							end
						end
						default: begin
							bad = 1'b1;
						end
					endcase
				end
			endcase

			if (bad) begin
				phase_n   = bacd_pkg::PH_FIRST;
				field_n   = bacd_pkg::FLD_OFFSET;
				bl_n      = 4'd0;
				acc_n     = 64'd0;
				skip_n    = 1'b1;
				req.valid = 1'b1;
				req.bad   = 1'b1;
			end else if (done) begin
				acc_n = 64'd0;
				unique case (field_e)
					bacd_pkg::FLD_OFFSET: begin
						saved_off_n = value;
						field_n     = bacd_pkg::FLD_SIZE;
					end
					bacd_pkg::FLD_SIZE: begin
						saved_size_n = value;
						field_n      = bacd_pkg::FLD_CHECK;
					end
					default: begin
						// The checksum is discarded; the cookie is complete.
						field_n   = bacd_pkg::FLD_OFFSET;
						req.valid = 1'b1;
						if (saved_size_q != 64'd0) begin
							req.off_inc = saved_off_q + 64'd1;
							req.size    = saved_size_q;
						end
					end
				endcase
			end
		end

		req.valid = req.valid & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= bacd_pkg::PH_FIRST;
			field_q      <= bacd_pkg::FLD_OFFSET;
			bl_q         <= 4'd0;
			acc_q        <= 64'd0;
			saved_off_q  <= 64'd0;
			saved_size_q <= 64'd0;
			skip_q       <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_n;
			field_q      <= field_n;
			bl_q         <= bl_n;
			acc_q        <= acc_n;
			saved_off_q  <= saved_off_n;
			saved_size_q <= saved_size_n;
			skip_q       <= skip_n;
		end
	end

	a_bad_sets_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.bad) |=> skip_q)
		else $error("bad marker transfer did not enter skipping");

	a_skip_restarted: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (phase_q == bacd_pkg::PH_FIRST && field_q == bacd_pkg::FLD_OFFSET))
		else $error("decoder is skipping with a partial cookie");

	a_multi_owes_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bacd_pkg::PH_MULTI) |-> (bl_q != 4'd0))
		else $error("multi-byte form with no bytes left");

endmodule

`default_nettype wire

// ===== rtl/bacd_scale.sv =====
// Scaling pipeline: operand register, 32x17 partial products, final add.
// Depends on bacd_pkg for the request struct.
`timescale 1ns / 1ps
`default_nettype none

module bacd_scale (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [16:0]          block_size,
	input  wire bacd_pkg::scale_req_t req,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [63:0]               file_offset,
	output logic [63:0]               block_bytes,
	output logic                      bad_marker
);

	logic        v_s1, v_s2, v_q;
	logic        bad_s1, bad_s2;
	logic [63:0] off_s1, size_s1;
	logic [48:0] off_lo_s2, size_lo_s2;
	logic [31:0] off_hi_s2, size_hi_s2;
	logic        adv_out, adv_s2, adv_s1;

	// Each stage moves when it is empty or the stage after it moves.
	assign adv_out  = !v_q || !out_stall;
	assign adv_s2   = !v_s2 || adv_out;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign out_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= req.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_out) v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			bad_s1  <= req.bad;
			off_s1  <= req.off_inc;
			size_s1 <= req.size;
		end
		if (adv_s2) begin
			bad_s2     <= bad_s1;
			off_lo_s2  <= 49'(off_s1[31:0]) * 49'(block_size);
			off_hi_s2  <= 32'(49'(off_s1[63:32]) * 49'(block_size));
			size_lo_s2 <= 49'(size_s1[31:0]) * 49'(block_size);
			size_hi_s2 <= 32'(49'(size_s1[63:32]) * 49'(block_size));
		end
		if (adv_out) begin
			bad_marker  <= bad_s2;
			file_offset <= 64'(off_lo_s2) + {off_hi_s2, 32'd0};
			block_bytes <= 64'(size_lo_s2) + {size_hi_s2, 32'd0};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/block_address_cookie_decoder.sv =====
// A result passes the operand, partial-product and output registers after its last byte.
// Throughput: one byte per cycle; the scaling pipeline (two stages and the output register)
// only stalls the byte side when all three hold a result and the result side stalls.
// Reset: asynchronous, active low; decoder restarts at the offset field, not skipping,
// block_size returns to 4096 and the pipeline is emptied.
// Depends on bacd_pkg, bacd_decoder and bacd_scale.
`timescale 1ns / 1ps
`default_nettype none

module block_address_cookie_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_data,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        cookie_start,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [63:0]      file_offset,
	output logic [63:0]      block_bytes,
	output logic             bad_marker
);

	logic [16:0]          block_size_q;
	logic                 ready;
	logic                 accept;
	bacd_pkg::scale_req_t req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= bacd_pkg::BLOCK_SIZE_RESET;
		end else if (cfg_we) begin
			block_size_q <= cfg_data;
		end
	end

	assign byte_stall = !ready;
	assign accept     = byte_valid && ready;

	bacd_decoder u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.cookie_start (cookie_start),
		.req          (req)
	);

	bacd_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.block_size  (block_size_q),
		.req         (req),
		.in_ready    (ready),
		.out_valid   (result_valid),
		.out_stall   (result_stall),
		.file_offset (file_offset),
		.block_bytes (block_bytes),
		.bad_marker  (bad_marker)
	);

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && bad_marker) |-> (file_offset == 64'd0 && block_bytes == 64'd0))
		else $error("bad marker result carries nonzero fields");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (result_valid && result_stall))
		else $error("byte side stalled while the output side can move");

	a_stall_in_reset: assert property (@(posedge clk)
		!arst_n |-> !byte_stall && !result_valid)
		else $error("pipeline not empty during reset");

endmodule

`default_nettype wire
